// ===== sv/fcm_pkg.sv =====
// Shared constants for the cluster-chain allocator.
package fcm_pkg;

   // table depth default and word width of one table entry
   localparam int TABLE_ENTRIES_DEF = 128;
   localparam int BLOCK_W           = 8;

   // end-of-chain marker, also "no block"
   localparam logic [BLOCK_W-1:0] NIL_BLOCK = 8'hFF;

endpackage

// ===== sv/fcm_table_ram.sv =====
// Allocation table RAM: one write port, one registered read port with write bypass.
module fcm_table_ram #(
   parameter int TABLE_ENTRIES = fcm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]     wr_addr,
   input  logic [fcm_pkg::BLOCK_W-1:0]          wr_data,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]     rd_addr,
   output logic [fcm_pkg::BLOCK_W-1:0]          rd_data
);
   import fcm_pkg::*;

   logic [BLOCK_W-1:0] mem [TABLE_ENTRIES];
   logic [BLOCK_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port; a same-cycle write to the read address is forwarded
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fat_chain_manager_top.sv =====
// Cluster-chain allocator: command sequencer around the allocation table RAM.
// One command at a time; the next is taken the cycle after the result word loads.
// Write entry and unused codes go from decode straight to the result; read next reads its link first.
// Result stalls hold the sequencer. Walks, free chain and count free read one table entry per cycle,
// up to TABLE_ENTRIES. Alloc append walks, then scans, then links the new block; drop tail is a walk
// plus a link fix. Reset (sync) clears control, first_data_block to 3; table kept.
module fat_chain_manager_top #(
   parameter int TABLE_ENTRIES = fcm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_func,
   input  logic [fcm_pkg::BLOCK_W-1:0]   req_block_index,
   input  logic [fcm_pkg::BLOCK_W-1:0]   req_entry_value,
   input  logic [fcm_pkg::BLOCK_W-1:0]   req_blocks_needed,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fcm_pkg::BLOCK_W-1:0]   rsp_link_value,
   output logic [fcm_pkg::BLOCK_W-1:0]   rsp_result_block,
   output logic [fcm_pkg::BLOCK_W-1:0]   rsp_block_count,
   output logic                          rsp_enough_space,
   output logic [1:0]                    rsp_status,
   // configuration
   input  logic                          csr_write_en,
   input  logic [6:0]                    csr_write_data
);
   import fcm_pkg::*;

   localparam int                 AW  = $clog2(TABLE_ENTRIES);
   localparam logic [BLOCK_W-1:0] TE8 = BLOCK_W'(TABLE_ENTRIES);
   localparam logic [6:0]         FDB_RESET = 7'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_LINK, S_WALK, S_FREE, S_SCAN, S_FIX, S_RESP
   } state_type;

   typedef enum logic [2:0] {
      F_WRITE, F_READ, F_ALLOC, F_FREE, F_DROP, F_TAIL, F_COUNT
   } func_type;

   typedef enum logic [1:0] {
      ST_OK, ST_NOFREE, ST_BROKEN, ST_EMPTY
   } status_type;

   // control registers
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         fdb_ff;

   // command word and working registers
   func_type           func_ff, func_in;
   logic [BLOCK_W-1:0] idx_ff, idx_in;
   logic [BLOCK_W-1:0] val_ff, val_in;
   logic [BLOCK_W-1:0] need_ff, need_in;
   logic [BLOCK_W-1:0] cur_ff, cur_in;
   logic [BLOCK_W-1:0] prev_ff, prev_in;
   logic [BLOCK_W-1:0] n_ff, n_in;
   logic [BLOCK_W-1:0] scan_ff, scan_in;
   logic [BLOCK_W-1:0] fcount_ff, fcount_in;
   logic [BLOCK_W-1:0] fixa_ff, fixa_in;
   logic [BLOCK_W-1:0] fixd_ff, fixd_in;
   logic               walk_empty_ff, walk_empty_in;

   // pending result
   logic [BLOCK_W-1:0] link_ff, link_in;
   logic [BLOCK_W-1:0] res_ff, res_in;
   logic [BLOCK_W-1:0] cnt_ff, cnt_in;
   logic               enough_ff, enough_in;
   status_type         st_ff, st_in;

   // output word
   logic [BLOCK_W-1:0] rsp_link_ff, rsp_res_ff, rsp_cnt_ff;
   logic               rsp_enough_ff;
   status_type         rsp_st_ff;

   // RAM port
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [BLOCK_W-1:0] mem_wdata, mem_rdata;

   logic               req_accept;
   logic               rsp_load;
   logic [BLOCK_W-1:0] scan_start;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign scan_start = {1'b0, fdb_ff};

   fcm_table_ram #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // command sequencer
   always_comb begin
      logic               do_scan;
      logic [BLOCK_W-1:0] v;
      logic [BLOCK_W-1:0] n_next;
      logic [BLOCK_W-1:0] scan_next;
      logic [BLOCK_W-1:0] fc;

      do_scan   = 1'b0;
      v         = mem_rdata;
      n_next    = n_ff + 8'd1;
      scan_next = scan_ff + 8'd1;
      fc        = fcount_ff + {7'd0, (mem_rdata == '0)};

      state_in      = state_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      n_in          = n_ff;
      scan_in       = scan_ff;
      fcount_in     = fcount_ff;
      fixa_in       = fixa_ff;
      fixd_in       = fixd_ff;
      walk_empty_in = walk_empty_ff;
      link_in       = link_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      enough_in     = enough_ff;
      st_in         = st_ff;

      mem_raddr = cur_ff[AW-1:0];
      mem_we    = 1'b0;
      mem_waddr = cur_ff[AW-1:0];
      mem_wdata = '0;
      rsp_load  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in  = func_type'(req_func);
               idx_in   = req_block_index;
               val_in   = req_entry_value;
               need_in  = req_blocks_needed;
               state_in = S_START;
            end
         end

         // decode the command and start the first table access
         S_START: begin
            link_in       = '0;
            res_in        = NIL_BLOCK;
            cnt_in        = '0;
            enough_in     = 1'b0;
            st_in         = ST_OK;
            n_in          = '0;
            prev_in       = NIL_BLOCK;
            cur_in        = idx_ff;
            fcount_in     = '0;
            walk_empty_in = 1'b0;
            state_in      = S_RESP;
            case (func_ff)
               F_WRITE: begin
                  if (idx_ff < TE8) begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_ff[AW-1:0];
                     mem_wdata = val_ff;
                  end else begin
                     st_in = ST_BROKEN;
                  end
               end
               F_READ: begin
                  if (idx_ff == NIL_BLOCK) begin
                     link_in = NIL_BLOCK;
                     st_in   = ST_EMPTY;
                  end else if (idx_ff >= TE8) begin
                     link_in = NIL_BLOCK;
                     st_in   = ST_BROKEN;
                  end else begin
                     mem_raddr = idx_ff[AW-1:0];
                     state_in  = S_LINK;
                  end
               end
               F_ALLOC, F_DROP, F_TAIL: begin
                  if (func_ff != F_DROP) begin
                     link_in = idx_ff;
                  end
                  if (idx_ff == NIL_BLOCK) begin
                     if (func_ff == F_ALLOC) begin
                        walk_empty_in = 1'b1;
                        do_scan       = 1'b1;
                     end else begin
                        st_in = ST_EMPTY;
                     end
                  end else if (idx_ff >= TE8) begin
                     st_in = ST_BROKEN;
                  end else begin
                     mem_raddr = idx_ff[AW-1:0];
                     state_in  = S_WALK;
                  end
               end
               F_FREE: begin
                  if (idx_ff == NIL_BLOCK) begin
                     st_in = ST_EMPTY;
                  end else if (idx_ff >= TE8) begin
                     st_in = ST_BROKEN;
                  end else begin
                     mem_raddr = idx_ff[AW-1:0];
                     state_in  = S_FREE;
                  end
               end
               F_COUNT: begin
                  do_scan = 1'b1;
                  cnt_in  = '0;
               end
               default: begin
               end
            endcase
         end

         S_LINK: begin
            link_in  = mem_rdata;
            state_in = S_RESP;
         end

         // one chain entry per cycle
         S_WALK: begin
            if (v == NIL_BLOCK) begin
               state_in = S_RESP;
               case (func_ff)
                  F_ALLOC: begin
                     fixa_in = cur_ff;
                     do_scan = 1'b1;
                  end
                  F_DROP: begin
                     mem_we    = 1'b1;
                     mem_waddr = cur_ff[AW-1:0];
                     mem_wdata = '0;
                     res_in    = cur_ff;
                     cnt_in    = 8'd1;
                     if (prev_ff == NIL_BLOCK) begin
                        link_in = NIL_BLOCK;
                        st_in   = ST_EMPTY;
                     end else begin
                        fixa_in  = prev_ff;
                        fixd_in  = NIL_BLOCK;
                        link_in  = idx_ff;
                        state_in = S_FIX;
                     end
                  end
                  default: begin
                     res_in = cur_ff;
                     cnt_in = n_next;
                  end
               endcase
            end else if ((v == '0) || (v >= TE8) || (n_next >= TE8)) begin
               st_in    = ST_BROKEN;
               state_in = S_RESP;
            end else begin
               prev_in   = cur_ff;
               cur_in    = v;
               n_in      = n_next;
               mem_raddr = v[AW-1:0];
            end
         end

         // free chain: clear each entry as it is read
         S_FREE: begin
            if (v == '0) begin
               st_in    = ST_BROKEN;
               cnt_in   = n_ff;
               state_in = S_RESP;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff[AW-1:0];
               mem_wdata = '0;
               cnt_in    = n_next;
               if (v == NIL_BLOCK) begin
                  state_in = S_RESP;
               end else if ((v >= TE8) || (n_next >= TE8)) begin
                  st_in    = ST_BROKEN;
                  state_in = S_RESP;
               end else begin
                  cur_in    = v;
                  n_in      = n_next;
                  mem_raddr = v[AW-1:0];
               end
            end
         end

         // ascending scan from first_data_block
         S_SCAN: begin
            if (func_ff == F_ALLOC) begin
               if (mem_rdata == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = scan_ff[AW-1:0];
                  mem_wdata = NIL_BLOCK;
                  res_in    = scan_ff;
                  st_in     = ST_OK;
                  if (walk_empty_ff) begin
                     link_in  = scan_ff;
                     state_in = S_RESP;
                  end else begin
                     fixd_in  = scan_ff;
                     state_in = S_FIX;
                  end
               end else if (scan_next >= TE8) begin
                  st_in    = ST_NOFREE;
                  state_in = S_RESP;
               end else begin
                  scan_in   = scan_next;
                  mem_raddr = scan_next[AW-1:0];
               end
            end else begin
               if (scan_next >= TE8) begin
                  cnt_in    = fc;
                  enough_in = (fc >= need_ff);
                  state_in  = S_RESP;
               end else begin
                  fcount_in = fc;
                  scan_in   = scan_next;
                  mem_raddr = scan_next[AW-1:0];
               end
            end
         end

         // second link update of append or drop
         S_FIX: begin
            mem_we    = 1'b1;
            mem_waddr = fixa_ff[AW-1:0];
            mem_wdata = fixd_ff;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // start a free-block scan, or finish at once when the range is empty
      if (do_scan) begin
         scan_in = scan_start;
         if (scan_start < TE8) begin
            mem_raddr = scan_start[AW-1:0];
            state_in  = S_SCAN;
         end else begin
            state_in = S_RESP;
            if (func_ff == F_ALLOC) begin
               st_in = ST_NOFREE;
            end else begin
               enough_in = (need_ff == '0);
            end
         end
      end
   end

   // output word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fdb_ff       <= FDB_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            fdb_ff <= csr_write_data;
         end
      end
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      n_ff          <= n_in;
      scan_ff       <= scan_in;
      fcount_ff     <= fcount_in;
      fixa_ff       <= fixa_in;
      fixd_ff       <= fixd_in;
      walk_empty_ff <= walk_empty_in;
      link_ff       <= link_in;
      res_ff        <= res_in;
      cnt_ff        <= cnt_in;
      enough_ff     <= enough_in;
      st_ff         <= st_in;
      if (rsp_load) begin
         rsp_link_ff   <= link_ff;
         rsp_res_ff    <= res_ff;
         rsp_cnt_ff    <= cnt_ff;
         rsp_enough_ff <= enough_ff;
         rsp_st_ff     <= st_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_link_value   = rsp_link_ff;
   assign rsp_result_block = rsp_res_ff;
   assign rsp_block_count  = rsp_cnt_ff;
   assign rsp_enough_space = rsp_enough_ff;
   assign rsp_status       = rsp_st_ff;

`ifndef SYNTHESIS
   // no table write while waiting for a command
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("table write while idle");

   // output register is only loaded when free or being taken
   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten");

   // accepted command is decoded next cycle
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_START))
      else $error("accepted command not decoded");

   // walk step count stays under the limit
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK) || (state_ff == S_FREE)) |-> (n_ff < TE8))
      else $error("walk exceeded step limit");

   // scan pointer stays inside the table
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff < TE8))
      else $error("scan left the table");
`endif

endmodule

// ===== dv/fat_chain_manager_top_tb.sv =====
// Self-checking testbench for the cluster-chain allocator: chain commands against a shadow table.
`timescale 1ns / 1ps

module fat_chain_manager_top_tb;
   import fcm_pkg::*;

   localparam int NBLK       = TABLE_ENTRIES_DEF;
   localparam int IDLE_LIMIT = 3000;   // cycles without any accepted word
   localparam int TAIL_WAIT  = 300;    // covers the longest command, an alloc append that walks and then scans

   typedef enum logic [2:0] {
      FN_WRITE, FN_READ, FN_ALLOC, FN_FREE, FN_DROP, FN_TAIL, FN_COUNT, FN_SPARE
   } func_type;

   typedef enum logic [1:0] {ST_OK, ST_NO_FREE, ST_BROKEN, ST_EMPTY} status_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] block_index;
      logic [7:0] entry_value;
      logic [7:0] blocks_needed;
   } cmd_type;

   typedef struct packed {
      logic [7:0] link_value;
      logic [7:0] result_block;
      logic [7:0] block_count;
      logic       enough_space;
      logic [1:0] status;
   } reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_func = 3'd0;
   logic [7:0] req_block_index = 8'd0;
   logic [7:0] req_entry_value = 8'd0;
   logic [7:0] req_blocks_needed = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_link_value;
   logic [7:0] rsp_result_block;
   logic [7:0] rsp_block_count;
   logic       rsp_enough_space;
   logic [1:0] rsp_status;
   logic       csr_write_en = 1'b0;
   logic [6:0] csr_write_data = 7'd0;

   // shadow of the allocation table and the block floor register
   logic [7:0] fat_shadow [0:NBLK-1];
   logic [6:0] first_blk = 7'd3;

   cmd_type    cmd_backlog [$];
   reply_type  replies_due [$];
   logic [7:0] chain_heads [$];
   cmd_type    on_wire;

   int errors = 0;
   int replies_checked = 0;
   int floor_settings = 1;
   int func_hits [0:7];
   int status_hits [0:3];

   fat_chain_manager_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_block_index   (req_block_index),
      .req_entry_value   (req_entry_value),
      .req_blocks_needed (req_blocks_needed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_link_value    (rsp_link_value),
      .rsp_result_block  (rsp_result_block),
      .rsp_block_count   (rsp_block_count),
      .rsp_enough_space  (rsp_enough_space),
      .rsp_status        (rsp_status),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   // follow a chain to its end marker; tail, predecessor and length on success
   function automatic logic [1:0] chase_chain(input logic [7:0] start, output logic [7:0] tail,
                                              output logic [7:0] prev, output logic [7:0] len);
      int cur;
      int n;
      logic [7:0] v;
      tail = 8'd0;
      prev = NIL_BLOCK;
      len  = 8'd0;
      if (start == NIL_BLOCK) return ST_EMPTY;
      if (start >= NBLK) return ST_BROKEN;
      cur = int'(start);
      for (n = 0; n < NBLK; n++) begin
         v = fat_shadow[cur];
         if (v == NIL_BLOCK) begin
            tail = 8'(cur);
            len  = 8'(n + 1);
            return ST_OK;
         end
         if (v == 8'd0 || v >= NBLK) return ST_BROKEN;
         prev = 8'(cur);
         cur  = int'(v);
      end
      return ST_BROKEN;
   endfunction

   function automatic logic [7:0] lowest_free();
      int i;
      for (i = int'(first_blk); i < NBLK; i++)
         if (fat_shadow[i] == 8'd0) return 8'(i);
      return NIL_BLOCK;
   endfunction

   // expected reply for one command; updates the shadow table
   function automatic reply_type predict_reply(input cmd_type c);
      reply_type  o;
      logic [1:0] st;
      logic [7:0] tail, prev, len, f, v;
      int         cur, n, i;
      o.link_value   = 8'd0;
      o.result_block = NIL_BLOCK;
      o.block_count  = 8'd0;
      o.enough_space = 1'b0;
      o.status       = ST_OK;
      case (c.func)
         FN_WRITE: begin
            if (c.block_index < NBLK) fat_shadow[c.block_index] = c.entry_value;
            else o.status = ST_BROKEN;
         end
         FN_READ: begin
            if (c.block_index == NIL_BLOCK) begin
               o.link_value = NIL_BLOCK;
               o.status     = ST_EMPTY;
            end else if (c.block_index >= NBLK) begin
               o.link_value = NIL_BLOCK;
               o.status     = ST_BROKEN;
            end else begin
               o.link_value = fat_shadow[c.block_index];
            end
         end
         FN_ALLOC: begin
            o.link_value = c.block_index;
            st = chase_chain(c.block_index, tail, prev, len);
            if (st == ST_BROKEN) begin
               o.status = ST_BROKEN;
            end else begin
               f = lowest_free();
               if (f == NIL_BLOCK) begin
                  o.status = ST_NO_FREE;
               end else begin
                  fat_shadow[f] = NIL_BLOCK;
                  if (st == ST_EMPTY) o.link_value = f;
                  else fat_shadow[tail] = f;
                  o.result_block = f;
               end
            end
         end
         FN_FREE: begin
            if (c.block_index == NIL_BLOCK) begin
               o.status = ST_EMPTY;
            end else if (c.block_index >= NBLK) begin
               o.status = ST_BROKEN;
            end else begin
               // free as we go; a broken link keeps what was already freed
               cur = int'(c.block_index);
               n   = 0;
               while (cur >= 0) begin
                  if (n >= NBLK) begin
                     o.status = ST_BROKEN;
                     cur = -1;
                  end else begin
                     v = fat_shadow[cur];
                     if (v == 8'd0) begin
                        o.status = ST_BROKEN;
                        cur = -1;
                     end else begin
                        fat_shadow[cur] = 8'd0;
                        n++;
                        if (v == NIL_BLOCK) begin
                           cur = -1;
                        end else if (v >= NBLK) begin
                           o.status = ST_BROKEN;
                           cur = -1;
                        end else begin
                           cur = int'(v);
                        end
                     end
                  end
               end
               o.block_count = 8'(n);
            end
         end
         FN_DROP: begin
            st = chase_chain(c.block_index, tail, prev, len);
            o.status = st;
            if (st == ST_OK) begin
               fat_shadow[tail] = 8'd0;
               o.result_block = tail;
               o.block_count  = 8'd1;
               if (prev == NIL_BLOCK) begin
                  o.link_value = NIL_BLOCK;
                  o.status     = ST_EMPTY;
               end else begin
                  fat_shadow[prev] = NIL_BLOCK;
                  o.link_value = c.block_index;
               end
            end
         end
         FN_TAIL: begin
            st = chase_chain(c.block_index, tail, prev, len);
            o.link_value = c.block_index;
            o.status     = st;
            if (st == ST_OK) begin
               o.result_block = tail;
               o.block_count  = len;
            end
         end
         FN_COUNT: begin
            n = 0;
            for (i = int'(first_blk); i < NBLK; i++)
               if (fat_shadow[i] == 8'd0) n++;
            o.block_count  = 8'(n);
            o.enough_space = (n >= int'(c.blocks_needed));
         end
         default: ;
      endcase
      return o;
   endfunction

   // next random command: mostly chain work on known heads, the rest noise
   function automatic cmd_type pick_cmd();
      cmd_type    c;
      int         r;
      logic [7:0] head;
      c.func          = FN_WRITE;
      c.block_index   = 8'($urandom_range(0, NBLK - 1));
      c.entry_value   = 8'($urandom_range(0, 255));
      c.blocks_needed = 8'($urandom_range(0, 255));
      head = (chain_heads.size() == 0) ? NIL_BLOCK
                                       : chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      r = int'($urandom_range(0, 99));
      if (r < 25) begin
         c.func = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0) c.block_index = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 0) c.entry_value = 8'd0;
      end else begin
         r = int'($urandom_range(0, 99));
         c.block_index = head;
         if (r < 35) begin
            c.func = FN_ALLOC;
            if (chain_heads.size() < 12 && $urandom_range(0, 4) == 0) c.block_index = NIL_BLOCK;
         end else if (r < 47) begin
            c.func = FN_TAIL;
         end else if (r < 62) begin
            c.func = FN_DROP;
         end else if (r < 80) begin
            c.func = FN_FREE;
         end else if (r < 90) begin
            c.func = FN_READ;
            c.block_index = 8'($urandom_range(0, NBLK - 1));
         end else begin
            c.func = FN_COUNT;
            c.blocks_needed = 8'($urandom_range(0, NBLK));
         end
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= 40)
         $display("mismatch on reply %0d, %s: got %0d expected %0d",
                  replies_checked, what, got, want);
   endtask

   task automatic queue_cmd(input logic [2:0] fn, input logic [7:0] idx, input logic [7:0] val,
                            input logic [7:0] need);
      cmd_type c;
      c.func          = fn;
      c.block_index   = idx;
      c.entry_value   = val;
      c.blocks_needed = need;
      do @(negedge clock); while (cmd_backlog.size() >= 4);
      cmd_backlog = {cmd_backlog, c};
   endtask

   // hold the sender until every reply is back
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || replies_due.size() != 0);
   endtask

   task automatic set_first_block(input logic [6:0] floor_blk);
      wait_drained();
      repeat (4) @(negedge clock);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= floor_blk;
      first_blk = floor_blk;
      @(posedge clock);
      csr_write_en <= 1'b0;
      floor_settings++;
   endtask

   task automatic random_phase(input int n_items);
      cmd_type c;
      int      k;
      for (k = 0; k < n_items; k++) begin
         c = pick_cmd();
         queue_cmd(c.func, c.block_index, c.entry_value, c.blocks_needed);
      end
   endtask

   // command driver: bursts of words with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      reply_type exp_r;
      cmd_type   nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            exp_r = predict_reply(on_wire);
            replies_due = {replies_due, exp_r};
            func_hits[on_wire.func]++;
            // track chain heads for the stimulus
            if (on_wire.func == FN_ALLOC && on_wire.block_index == NIL_BLOCK &&
                exp_r.status == ST_OK)
               chain_heads = {chain_heads, exp_r.result_block};
            if (on_wire.func == FN_FREE ||
                (on_wire.func == FN_DROP && exp_r.status == ST_EMPTY)) begin
               for (int i = chain_heads.size() - 1; i >= 0; i--)
                  if (chain_heads[i] == on_wire.block_index) chain_heads.delete(i);
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               nxt = cmd_backlog.pop_front();
               on_wire           <= nxt;
               req_func          <= nxt.func;
               req_block_index   <= nxt.block_index;
               req_entry_value   <= nxt.entry_value;
               req_blocks_needed <= nxt.blocks_needed;
               req_valid         <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = int'($urandom_range(0, 24));
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 10));
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // reply monitor: stall pattern redrawn on a timer: none, light or heavy
   int stall_mode  = 0;
   int stall_timer = 0;

   always @(posedge clock) begin
      reply_type exp_r;
      if (!reset) begin
         if (stall_timer == 0) begin
            stall_mode  = int'($urandom_range(0, 2));
            stall_timer = 50;
         end
         stall_timer--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               report_mismatch("reply with nothing outstanding", int'(rsp_status), 0);
            end else begin
               exp_r = replies_due.pop_front();
               if (rsp_link_value !== exp_r.link_value)
                  report_mismatch("link_value", int'(rsp_link_value),
                                  int'(exp_r.link_value));
               if (rsp_result_block !== exp_r.result_block)
                  report_mismatch("result_block", int'(rsp_result_block),
                                  int'(exp_r.result_block));
               if (rsp_block_count !== exp_r.block_count)
                  report_mismatch("block_count", int'(rsp_block_count),
                                  int'(exp_r.block_count));
               if (rsp_enough_space !== exp_r.enough_space)
                  report_mismatch("enough_space", int'(rsp_enough_space),
                                  int'(exp_r.enough_space));
               if (rsp_status !== exp_r.status)
                  report_mismatch("status", int'(rsp_status), int'(exp_r.status));
               status_hits[exp_r.status]++;
            end
            replies_checked++;
         end
      end
   end

   // watchdog on accepted words
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("fat_chain_manager_top_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i;
      for (i = 0; i < 8; i++) func_hits[i] = 0;
      for (i = 0; i < 4; i++) status_hits[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // load the whole table as free before anything reads it
      for (i = 0; i < NBLK; i++) queue_cmd(FN_WRITE, 8'(i), 8'd0, 8'd0);

      // directed: odd codes, range errors, chain life cycle, broken chains, counts
      queue_cmd(FN_SPARE, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(FN_WRITE, 8'd200, 8'd5, 8'd0);
      queue_cmd(FN_READ,  NIL_BLOCK, 8'd0, 8'd0);
      queue_cmd(FN_READ,  8'd128, 8'd0, 8'd0);
      queue_cmd(FN_ALLOC, NIL_BLOCK, 8'd0, 8'd0);   // new chain at the floor
      queue_cmd(FN_ALLOC, 8'd3, 8'd0, 8'd0);
      queue_cmd(FN_TAIL,  8'd3, 8'd0, 8'd0);
      queue_cmd(FN_DROP,  8'd3, 8'd0, 8'd0);
      queue_cmd(FN_DROP,  8'd3, 8'd0, 8'd0);        // only block left
      queue_cmd(FN_DROP,  NIL_BLOCK, 8'd0, 8'd0);
      queue_cmd(FN_ALLOC, NIL_BLOCK, 8'd0, 8'd0);
      queue_cmd(FN_ALLOC, 8'd3, 8'd0, 8'd0);
      queue_cmd(FN_FREE,  8'd3, 8'd0, 8'd0);
      queue_cmd(FN_FREE,  NIL_BLOCK, 8'd0, 8'd0);
      queue_cmd(FN_FREE,  8'd130, 8'd0, 8'd0);
      queue_cmd(FN_ALLOC, 8'd140, 8'd0, 8'd0);
      queue_cmd(FN_WRITE, 8'd10, 8'd10, 8'd0);      // self loop: walk runs too long
      queue_cmd(FN_TAIL,  8'd10, 8'd0, 8'd0);
      queue_cmd(FN_WRITE, 8'd11, 8'd200, 8'd0);     // link out of range
      queue_cmd(FN_ALLOC, 8'd11, 8'd0, 8'd0);
      queue_cmd(FN_FREE,  8'd12, 8'd0, 8'd0);       // chain starting on a free entry
      queue_cmd(FN_WRITE, 8'd127, 8'hFF, 8'd0);
      queue_cmd(FN_COUNT, 8'd0, 8'd0, 8'd0);
      queue_cmd(FN_COUNT, 8'd0, 8'd0, 8'd128);
      queue_cmd(FN_COUNT, 8'd0, 8'd0, 8'hFF);

      random_phase(260);
      set_first_block(7'd0);
      random_phase(260);
      set_first_block(7'd127);
      // only the top block can be handed out: second request finds nothing
      queue_cmd(FN_WRITE, 8'd127, 8'd0, 8'd0);
      queue_cmd(FN_ALLOC, NIL_BLOCK, 8'd0, 8'd0);
      queue_cmd(FN_ALLOC, NIL_BLOCK, 8'd0, 8'd0);
      queue_cmd(FN_FREE,  8'd127, 8'd0, 8'd0);
      random_phase(120);
      set_first_block(7'($urandom_range(1, 126)));
      random_phase(250);

      wait_drained();
      repeat (TAIL_WAIT) @(negedge clock);
      if (replies_due.size() != 0)
         report_mismatch("replies never returned", replies_due.size(), 0);

      $display("checked %0d replies over %0d block-floor settings; writes %0d reads %0d",
               replies_checked, floor_settings, func_hits[FN_WRITE], func_hits[FN_READ]);
      $display("alloc %0d free %0d drop %0d tail %0d count %0d; no-free %0d broken %0d empty %0d",
               func_hits[FN_ALLOC], func_hits[FN_FREE], func_hits[FN_DROP], func_hits[FN_TAIL],
               func_hits[FN_COUNT], status_hits[ST_NO_FREE], status_hits[ST_BROKEN],
               status_hits[ST_EMPTY]);
      if (errors == 0) begin
         $display("fat_chain_manager_top_tb OK");
      end else begin
         $display("fat_chain_manager_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== fat_chain_manager_top.f =====
sv/fcm_pkg.sv
sv/fcm_table_ram.sv
sv/fat_chain_manager_top.sv
dv/fat_chain_manager_top_tb.sv
